### rtl/srcmp_pkg.sv
// shared types, register codes and constant tables for the stereo rms compressor
package srcmp_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LOG_DEPTH_DEF   = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd5;

  localparam logic               ENABLE_RST    = 1'b1;
  localparam logic signed [14:0] THRESHOLD_RST = -15'sd4608;
  localparam logic [15:0]        SLOPE_RST     = 16'd49152;
  localparam logic [23:0]        ATTACK_RST    = 24'd16739215;
  localparam logic [23:0]        RELEASE_RST   = 24'd16772461;
  localparam logic [14:0]        MAKEUP_RST    = 15'd4096;

  localparam int          LEVEL_FLOOR   = -30720;
  localparam logic [18:0] DB_PER_LOG2   = 19'd197283;
  localparam logic [13:0] LOG2_PER_DB20 = 14'd10885;
  localparam logic [23:0] GAIN_MAX      = 24'hFFFFFF;

  typedef struct packed {
    logic               enable;
    logic signed [14:0] threshold_level;
    logic [15:0]        over_slope;
    logic [23:0]        attack_weight;
    logic [23:0]        release_weight;
    logic [14:0]        makeup_gain;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       bypass;
    logic       last;
    logic [1:0] count;
  } fr_stat_t;

  typedef struct packed {
    logic take;
    logic load;
  } bk_stat_t;

  typedef logic [29:0] exp_rom_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-(k+1)) in q0.30 by repeated square roots of one half
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    t;
    logic [63:0] x;
    x = isqrt64(64'h1 << 59);
    t[0] = x[29:0];
    for (int k = 1; k < 16; k++) begin
      x = isqrt64(x << 30);
      t[k] = x[29:0];
    end
    return t;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // log2(1 + i/depth) in q0.16 by repeated squaring, depth = 2^lb
  function automatic logic [15:0] log_entry(input int lb, input int i);
    logic [63:0] x;
    logic [15:0] res;
    x = 64'((64'h1 << lb) + 64'(i)) << (30 - lb);
    res = '0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      res = res << 1;
      if (x >= (64'h1 << 31)) begin
        res = res | 16'h1;
        x = x >> 1;
      end
    end
    return res;
  endfunction

endpackage

### rtl/srcmp_front.sv
// front end: two-entry frame queue that tags each frame as bypass or compress
module srcmp_front import srcmp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enable,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] left_in,
  input  logic signed [SAMPLE_BITS-1:0] right_in,
  input  logic                          frame_last,
  input  logic                          take,
  output fr_stat_t                      stat,
  output logic signed [SAMPLE_BITS-1:0] left_q,
  output logic signed [SAMPLE_BITS-1:0] right_q
);

  localparam int EW = 2 * SAMPLE_BITS + 2;

  logic [EW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          wr_en;
  logic [EW-1:0] head;

  assign full  = (count_r == 2'd2);
  assign wr_en = push && !full;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ take;
    count_nxt  = count_r + 2'(wr_en) - 2'(take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= {!enable, frame_last, left_in, right_in};
    end
  end

  always_comb begin
    stat.valid  = (count_r != 2'd0);
    stat.bypass = head[EW-1];
    stat.last   = head[EW-2];
    stat.count  = count_r;
    left_q      = head[2*SAMPLE_BITS-1:SAMPLE_BITS];
    right_q     = head[SAMPLE_BITS-1:0];
  end

endmodule

### rtl/srcmp_back.sv
// back end: sequencer for level detect, gain computer, smoothing and output scaling
module srcmp_back import srcmp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LOG_DEPTH   = LOG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cfg_t                          cfg,
  input  fr_stat_t                      fr,
  input  logic signed [SAMPLE_BITS-1:0] left_q,
  input  logic signed [SAMPLE_BITS-1:0] right_q,
  output bk_stat_t                      stat,
  output logic [23:0]                   gain,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          buffer_end
);

  localparam int S   = SAMPLE_BITS;
  localparam int MW  = 2 * S - 1;
  localparam int NS  = $clog2(MW);
  localparam int LB  = $clog2(LOG_DEPTH);
  localparam int L2W = NS + 18;
  localparam int PW  = L2W + 19;
  localparam int LVW = PW - 24;
  localparam int YW  = S + 28;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SQL  = 5'd1;
  localparam logic [4:0] ST_SQR  = 5'd2;
  localparam logic [4:0] ST_SUM  = 5'd3;
  localparam logic [4:0] ST_NORM = 5'd4;
  localparam logic [4:0] ST_LUT  = 5'd5;
  localparam logic [4:0] ST_LOGM = 5'd6;
  localparam logic [4:0] ST_LEV  = 5'd7;
  localparam logic [4:0] ST_RED  = 5'd8;
  localparam logic [4:0] ST_TQ   = 5'd9;
  localparam logic [4:0] ST_EXP  = 5'd10;
  localparam logic [4:0] ST_GSH  = 5'd11;
  localparam logic [4:0] ST_SM1  = 5'd12;
  localparam logic [4:0] ST_SM2  = 5'd13;
  localparam logic [4:0] ST_MK   = 5'd14;
  localparam logic [4:0] ST_OL   = 5'd15;
  localparam logic [4:0] ST_ORT  = 5'd16;
  localparam logic [4:0] ST_DONE = 5'd17;

  typedef logic [15:0] log_rom_t [LOG_DEPTH];

  function automatic log_rom_t build_log_rom();
    log_rom_t t;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      t[i] = log_entry(LB, i);
    end
    return t;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

  function automatic logic signed [S-1:0] sat(input logic signed [YW-1:0] y);
    logic signed [S+3:0] ys;
    ys = y[YW-1:24];
    if (ys > $signed({5'b0, {(S-1){1'b1}}})) begin
      return {1'b0, {(S-1){1'b1}}};
    end else if (ys < $signed({5'b11111, {(S-1){1'b0}}})) begin
      return {1'b1, {(S-1){1'b0}}};
    end
    return ys[S-1:0];
  endfunction

  logic [4:0]            state_r, state_nxt;
  logic [4:0]            cnt_r;
  logic signed [S-1:0]   l_r, r_r;
  logic                  last_r;
  logic [MW-1:0]         sql_r, sqr_r, m_r;
  logic                  zero_r;
  logic [NS-1:0]         sh_r;
  logic [15:0]           rom_r;
  logic signed [PW-1:0]  prod_r;
  logic [15:0]           diff_r;
  logic [15:0]           red_r;
  logic [21:0]           t_r;
  logic [30:0]           g_r;
  logic [23:0]           gn_r;
  logic [23:0]           w_r;
  logic [47:0]           p_r;
  logic [23:0]           s_r;
  logic [26:0]           gm_r;
  logic signed [S-1:0]   yl_r, yr_r;
  logic                  ov_r;
  logic signed [S-1:0]   ol_r, or_r;
  logic                  oe_r;

  logic                  take, load;
  logic signed [2*S-1:0] sq_full;
  logic [MW:0]           sum;
  logic [MW-1:0]         amt;
  logic                  top_zero;
  logic signed [L2W-1:0] l2;
  logic signed [LVW-1:0] levw, lev;
  logic signed [LVW:0]   diff;
  logic [31:0]           red_p;
  logic [29:0]           t_p;
  logic [60:0]           g_p;
  logic [5:0]            ip;
  logic [24:0]           gs;
  logic [23:0]           wsel;
  logic [48:0]           acc;
  logic [24:0]           s_new;
  logic [38:0]           gm_p;
  logic signed [YW-1:0]  y_p;

  assign take = (state_r == ST_IDLE) && fr.valid;
  assign load = (state_r == ST_DONE) && (!ov_r || out_pop);
  assign stat = '{take: take, load: load};
  assign gain = s_r;

  always_comb begin
    sq_full  = (state_r == ST_SQL) ? l_r * l_r : r_r * r_r;
    sum      = (MW+1)'(sql_r) + (MW+1)'(sqr_r);
    amt      = MW'(1) << cnt_r;
    top_zero = ((m_r >> (MW'(MW) - amt)) == '0);
    l2       = $signed({{(NS+2){1'b0}}, rom_r}) - $signed({2'b00, sh_r, 16'h0});
    levw     = prod_r[PW-1:24];
    lev      = (zero_r || levw < LVW'(LEVEL_FLOOR)) ? LVW'(LEVEL_FLOOR) : levw;
    diff     = (LVW+1)'(lev) - (LVW+1)'(cfg.threshold_level);
    red_p    = 32'(diff_r) * 32'(cfg.over_slope);
    t_p      = 30'(red_r) * 30'(LOG2_PER_DB20);
    g_p      = 61'(g_r) * 61'(EXP_ROM[cnt_r[3:0]]);
    ip       = t_r[21:16];
    gs       = (ip >= 6'd32) ? 25'd0 : 25'(g_r >> 6) >> ip;
    wsel     = (gn_r < s_r) ? cfg.attack_weight : cfg.release_weight;
    acc      = 49'(p_r) + 49'(gn_r) * (49'h1000000 - 49'(w_r));
    s_new    = acc[48:24];
    gm_p     = 39'(s_r) * 39'(cfg.makeup_gain);
    y_p      = ((state_r == ST_OL) ? YW'(l_r) : YW'(r_r)) * $signed({1'b0, gm_r});
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (fr.valid) state_nxt = fr.bypass ? ST_DONE : ST_SQL;
      ST_SQL:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_NORM;
      ST_NORM: if (cnt_r == 5'd0) state_nxt = ST_LUT;
      ST_LUT:  state_nxt = ST_LOGM;
      ST_LOGM: state_nxt = ST_LEV;
      ST_LEV:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_TQ;
      ST_TQ:   state_nxt = ST_EXP;
      ST_EXP:  if (cnt_r == 5'd15) state_nxt = ST_GSH;
      ST_GSH:  state_nxt = ST_SM1;
      ST_SM1:  state_nxt = ST_SM2;
      ST_SM2:  state_nxt = ST_MK;
      ST_MK:   state_nxt = ST_OL;
      ST_OL:   state_nxt = ST_ORT;
      ST_ORT:  state_nxt = ST_DONE;
      ST_DONE: if (load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s_r     <= GAIN_MAX;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_SM2) begin
        s_r <= (s_new > 25'(GAIN_MAX)) ? GAIN_MAX : s_new[23:0];
      end
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        l_r    <= left_q;
        r_r    <= right_q;
        last_r <= fr.last;
        yl_r   <= left_q;
        yr_r   <= right_q;
      end
      ST_SQL: sql_r <= sq_full[MW-1:0];
      ST_SQR: sqr_r <= sq_full[MW-1:0];
      ST_SUM: begin
        m_r    <= sum[MW:1];
        zero_r <= (sum[MW:1] == '0);
        sh_r   <= '0;
        cnt_r  <= 5'(NS - 1);
      end
      ST_NORM: begin
        if (top_zero) begin
          m_r  <= m_r << amt;
          sh_r <= sh_r + NS'(amt);
        end
        cnt_r <= cnt_r - 5'd1;
      end
      ST_LUT:  rom_r <= LOG_ROM[m_r[MW-2 -: LB]];
      ST_LOGM: prod_r <= PW'(l2) * $signed(PW'(DB_PER_LOG2));
      ST_LEV:  diff_r <= (diff > 0) ? diff[15:0] : 16'd0;
      ST_RED:  red_r <= red_p[31:16];
      ST_TQ: begin
        t_r   <= t_p[29:8];
        g_r   <= 31'h40000000;
        cnt_r <= 5'd0;
      end
      ST_EXP: begin
        if (t_r[4'd15 - cnt_r[3:0]]) g_r <= g_p[60:30];
        cnt_r <= cnt_r + 5'd1;
      end
      ST_GSH: gn_r <= (gs > 25'(GAIN_MAX)) ? GAIN_MAX : gs[23:0];
      ST_SM1: begin
        w_r <= wsel;
        p_r <= 48'(s_r) * 48'(wsel);
      end
      ST_SM2: ;
      ST_MK:  gm_r <= gm_p[38:12];
      ST_OL:  yl_r <= sat(y_p);
      ST_ORT: yr_r <= sat(y_p);
      ST_DONE: begin
        if (load) begin
          ol_r <= yl_r;
          or_r <= yr_r;
          oe_r <= last_r;
        end
      end
      default: ;
    endcase
  end

  assign out_empty  = !ov_r;
  assign left_out   = ol_r;
  assign right_out  = or_r;
  assign buffer_end = oe_r;

endmodule

### rtl/stereo_rms_compressor.sv
// top level: configuration registers, frame queue and compressor sequencer
// the back-end sequencer works on one frame at a time and takes the next only once its
// result is loaded into the free result register; enabled frames pass through the level
// detect and the shared q0.30 exponent multiply loop, disabled (bypass) frames skip them
// reset: synchronous active-low rst_n restores register defaults, unity smoothed gain,
// and empties the frame queue and result register
module stereo_rms_compressor import srcmp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LOG_DEPTH   = LOG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  input  logic                          in_frame_last,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  output logic                          out_buffer_end
);

  cfg_t                          cfg_r;
  fr_stat_t                      fr_stat;
  bk_stat_t                      bk_stat;
  logic signed [SAMPLE_BITS-1:0] fr_left, fr_right;
  logic [23:0]                   gain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable          <= ENABLE_RST;
      cfg_r.threshold_level <= THRESHOLD_RST;
      cfg_r.over_slope      <= SLOPE_RST;
      cfg_r.attack_weight   <= ATTACK_RST;
      cfg_r.release_weight  <= RELEASE_RST;
      cfg_r.makeup_gain     <= MAKEUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:    cfg_r.enable          <= cfg_data[0];
        REG_THRESHOLD: cfg_r.threshold_level <= cfg_data[14:0];
        REG_SLOPE:     cfg_r.over_slope      <= cfg_data[15:0];
        REG_ATTACK:    cfg_r.attack_weight   <= cfg_data[23:0];
        REG_RELEASE:   cfg_r.release_weight  <= cfg_data[23:0];
        REG_MAKEUP:    cfg_r.makeup_gain     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  srcmp_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .enable     (cfg_r.enable),
    .push       (in_push),
    .full       (in_full),
    .left_in    (in_left_in),
    .right_in   (in_right_in),
    .frame_last (in_frame_last),
    .take       (bk_stat.take),
    .stat       (fr_stat),
    .left_q     (fr_left),
    .right_q    (fr_right)
  );

  srcmp_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LOG_DEPTH  (LOG_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fr         (fr_stat),
    .left_q     (fr_left),
    .right_q    (fr_right),
    .stat       (bk_stat),
    .gain       (gain),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .left_out   (out_left_out),
    .right_out  (out_right_out),
    .buffer_end (out_buffer_end)
  );

`ifndef SYNTH
  a_queue_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> (fr_stat.count != 2'd0))
    else $error("frame queue lost an accepted beat");

  a_gain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_r.enable && $past(!cfg_r.enable)) |-> $stable(gain))
    else $error("smoothed gain moved while disabled");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.load |=> !out_empty)
    else $error("loaded result not visible");

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.take |-> fr_stat.valid)
    else $error("back end took from an empty queue");
`endif

endmodule

### test/stereo_rms_compressor_check.sv
// checker for the stereo rms compressor: predicts each frame and compares results
`timescale 1ns / 100ps
module stereo_rms_compressor_check import srcmp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_push,
  input  logic                   in_full,
  input  logic signed [23:0]     in_left_in,
  input  logic signed [23:0]     in_right_in,
  input  logic                   in_frame_last,
  input  logic                   out_empty,
  input  logic                   out_pop,
  input  logic signed [23:0]     out_left_out,
  input  logic signed [23:0]     out_right_out,
  input  logic                   out_buffer_end,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    logic        last;
  } frame_t;

  frame_t      frames_due[$];
  cfg_t        regs;
  logic [23:0] gain_state;
  logic [15:0] log_tab [256];
  logic [63:0] pow_tab [16];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  initial begin
    logic [63:0] x;
    logic [15:0] acc;
    for (int i = 0; i < 256; i++) begin
      x = (64'(256 + i) << 30) / 256;
      acc = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        acc = acc << 1;
        if (x >= (64'h1 << 31)) begin
          acc = acc | 16'h1;
          x = x >> 1;
        end
      end
      log_tab[i] = acc;
    end
    pow_tab[0] = int_sqrt(64'h1 << 59);
    for (int k = 1; k < 16; k++) pow_tab[k] = int_sqrt(pow_tab[k-1] << 30);
  end

  function automatic longint level_db(input logic [63:0] m);
    int          e;
    logic [63:0] frac;
    longint      l2;
    longint      lev;
    if (m == 0) return LEVEL_FLOOR;
    e = 63;
    while (!m[e]) e--;
    frac = m << (63 - e);
    l2 = longint'(e - 2 * (SAMPLE_BITS_DEF - 1)) * 65536 + longint'(log_tab[frac[62:55]]);
    lev = (l2 * longint'(DB_PER_LOG2)) >>> 24;
    return (lev < LEVEL_FLOOR) ? LEVEL_FLOOR : lev;
  endfunction

  function automatic logic [23:0] gain_of(input logic [63:0] red);
    logic [63:0] t;
    logic [63:0] g;
    t = (red * 64'(LOG2_PER_DB20)) >> 8;
    g = 64'h1 << 30;
    for (int k = 0; k < 16; k++)
      if (t[15-k]) g = (g * pow_tab[k]) >> 30;
    g = g >> 6;
    if ((t >> 16) >= 32) g = 0;
    else g = g >> (t >> 16);
    return (g > 64'(GAIN_MAX)) ? GAIN_MAX : g[23:0];
  endfunction

  function automatic logic [23:0] scale_sat(input longint x, input longint gm);
    longint y;
    y = (x * gm) >>> 24;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    return y[23:0];
  endfunction

  function automatic frame_t compress(input logic signed [23:0] l, input logic signed [23:0] r,
                                      input logic last);
    frame_t      f;
    longint      ls;
    longint      rs;
    logic [63:0] m;
    longint      lev;
    logic [63:0] red;
    logic [23:0] g;
    logic [63:0] w;
    logic [63:0] s;
    longint      gm;
    ls = l;
    rs = r;
    f.last = last;
    if (!regs.enable) begin
      f.left = l;
      f.right = r;
      return f;
    end
    m = (64'(ls * ls) + 64'(rs * rs)) >> 1;
    lev = level_db(m);
    red = 0;
    if (lev > longint'(regs.threshold_level))
      red = (64'(lev - longint'(regs.threshold_level)) * 64'(regs.over_slope)) >> 16;
    g = gain_of(red);
    w = (g < gain_state) ? 64'(regs.attack_weight) : 64'(regs.release_weight);
    s = (64'(gain_state) * w + 64'(g) * ((64'h1 << 24) - w)) >> 24;
    gain_state = (s > 64'(GAIN_MAX)) ? GAIN_MAX : s[23:0];
    gm = longint'((64'(gain_state) * 64'(regs.makeup_gain)) >> 12);
    f.left = scale_sat(ls, gm);
    f.right = scale_sat(rs, gm);
    return f;
  endfunction

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    $display("%0t %s: got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = frames_due.size();

  always @(posedge clk) begin
    frame_t f;
    if (!rst_n) begin
      regs <= '{ENABLE_RST, THRESHOLD_RST, SLOPE_RST, ATTACK_RST, RELEASE_RST, MAKEUP_RST};
      gain_state = GAIN_MAX;
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:    regs.enable <= cfg_data[0];
          REG_THRESHOLD: regs.threshold_level <= cfg_data[14:0];
          REG_SLOPE:     regs.over_slope <= cfg_data[15:0];
          REG_ATTACK:    regs.attack_weight <= cfg_data[23:0];
          REG_RELEASE:   regs.release_weight <= cfg_data[23:0];
          REG_MAKEUP:    regs.makeup_gain <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) frames_due.push_back(compress(in_left_in, in_right_in, in_frame_last));
      if (out_pop && !out_empty) begin
        if (frames_due.size() == 0) begin
          $display("%0t unexpected result beat", $time);
          fail_count++;
        end else begin
          f = frames_due.pop_front();
          if (out_left_out !== f.left) report("left_out", out_left_out, f.left);
          if (out_right_out !== f.right) report("right_out", out_right_out, f.right);
          if (out_buffer_end !== f.last) report("buffer_end", 24'(out_buffer_end), 24'(f.last));
        end
      end
    end
  end

endmodule

### test/stereo_rms_compressor_test.sv
// testbench top for the stereo rms compressor: stimulus, idling and verdict
`timescale 1ns / 100ps
module stereo_rms_compressor_test;
  import srcmp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 5000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_push;
  logic                  in_full;
  logic signed [23:0]    in_left_in;
  logic signed [23:0]    in_right_in;
  logic                  in_frame_last;
  logic                  out_empty;
  logic                  out_pop;
  logic signed [23:0]    out_left_out;
  logic signed [23:0]    out_right_out;
  logic                  out_buffer_end;
  int                    fail_count;
  int                    pending;

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int quiet_cycles;

  stereo_rms_compressor u_top (.*);

  stereo_rms_compressor_check u_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("stereo_rms_compressor: mismatch");
        $finish;
      end
    end
  end

  initial begin
    out_pop = 1'b0;
    hold_req = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      out_pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain;
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send(input logic [23:0] l, input logic [23:0] r, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_left_in <= l;
    in_right_in <= r;
    in_frame_last <= last;
    do @(posedge clk); while (in_full);
    @(negedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    logic [23:0] v;
    case ($urandom_range(3))
      0: v = 24'($urandom);
      1: v = 24'($urandom_range(8388607) >> $urandom_range(23));
      2: v = -24'($urandom_range(8388607) >> $urandom_range(12));
      default: v = 24'($urandom_range(2000)) - 24'd1000;
    endcase
    return v;
  endfunction

  task automatic random_frames(input int n);
    logic [23:0] l;
    for (int i = 0; i < n; i++) begin
      l = rand_sample();
      if ($urandom_range(4) == 0) send(l, l, 1'($urandom_range(1)));
      else send(l, rand_sample(), 1'($urandom_range(1)));
    end
  endtask

  task automatic set_regs(input logic en, input logic signed [14:0] thr, input logic [15:0] slope,
                          input logic [23:0] att, input logic [23:0] rel, input logic [14:0] mk);
    drain();
    write_reg(REG_ENABLE, 24'(en));
    write_reg(REG_THRESHOLD, 24'(thr));
    write_reg(REG_SLOPE, 24'(slope));
    write_reg(REG_ATTACK, att);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_MAKEUP, 24'(mk));
  endtask

  task automatic set_mode(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_push = 1'b0;
    in_left_in = '0;
    in_right_in = '0;
    in_frame_last = 1'b0;
    set_mode(25, 76);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed frames at reset settings
    send(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send(24'h800000, 24'h800000, 1'b1);
    send(24'h7FFFFF, 24'h800000, 1'b0);
    send(24'h000000, 24'h000000, 1'b1);
    send(24'h000001, 24'hFFFFFF, 1'b0);
    send(24'h400000, 24'h000000, 1'b0);
    send(24'h000000, 24'hC00000, 1'b1);
    send(24'h000000, 24'h000000, 1'b0);
    send(24'h100000, 24'h0FFFFF, 1'b0);
    set_regs(1'b0, THRESHOLD_RST, SLOPE_RST, ATTACK_RST, RELEASE_RST, MAKEUP_RST);
    send(24'h7FFFFF, 24'h800000, 1'b1);
    send(24'h000000, 24'h123456, 1'b0);
    set_regs(1'b1, -15'sd12800, 16'd62259, 24'd0, 24'd0, 15'd16384);
    write_reg(REG_SPARE, 24'hFFFFFF);
    write_reg(REG_SPARE_HI, 24'h000000);
    send(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send(24'h000010, 24'h000000, 1'b1);
    send(24'h800000, 24'h7FFFFF, 1'b0);
    set_regs(1'b1, 15'sd0, 16'd65535, 24'hFFFFFF, 24'hFFFFFF, 15'd1024);
    send(24'h7FFFFF, 24'h800000, 1'b1);
    send(24'h000000, 24'h000000, 1'b0);

    random_frames(150);
    set_regs(1'b1, THRESHOLD_RST, SLOPE_RST, ATTACK_RST, RELEASE_RST, MAKEUP_RST);
    random_frames(200);
    set_regs(1'b1, -15'sd12800, 16'd62259, 24'd16000000, 24'd16700000, 15'd16384);
    random_frames(200);

    set_mode(76, 25);
    set_regs(1'b0, -15'sd2000, 16'd30000, 24'd1000, 24'd2000, 15'd8000);
    random_frames(150);
    set_regs(1'b1, 15'sd16383, 16'd0, 24'd0, 24'hFFFFFF, 15'd32767);
    random_frames(150);
    set_regs(1'b1, -15'sd16384, 16'd65535, 24'd8388608, 24'd12000000, 15'd1024);
    random_frames(200);

    set_mode(0, 0);
    set_regs(1'b1, THRESHOLD_RST, 16'd62259, 24'd15000000, 24'd16772461, 15'd12000);
    hold_req = 1'b1;
    random_frames(60);
    drain();
    random_frames(150);
    set_regs(1'b1, -15'sd6000, 16'd40000, 24'hFFFFFF, 24'd0, 15'd4096);
    random_frames(200);
    set_regs(1'b1, -15'sd300, 16'd20000, 24'd16739215, 24'd16772461, 15'd2048);
    random_frames(150);

    drain();
    if (fail_count == 0) begin
      $display("stereo_rms_compressor: match");
    end else begin
      $display("stereo_rms_compressor: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/srcmp_pkg.sv
rtl/srcmp_front.sv
rtl/srcmp_back.sv
rtl/stereo_rms_compressor.sv
test/stereo_rms_compressor_check.sv
test/stereo_rms_compressor_test.sv
